// ===== hw/rtl/cpsa_pkg.sv =====
// Shared widths, register indexes and the greyscale palette table of the pair allocator.
package cpsa_pkg;

  localparam int COLOR_W       = 8;
  localparam int KEY_W         = 2 * COLOR_W;
  localparam int SLOT_W        = 8;
  localparam int LIMIT_W       = 17;
  localparam int BASE_W        = 8;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_IDX_W     = 1;
  localparam int TABLE_DEPTH_D = 256;
  localparam int RST_BASE      = 16;
  localparam int PALETTE_N     = 1 << COLOR_W;

  localparam logic [LIMIT_W-1:0] RST_LIMIT = LIMIT_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BASE = 1'b1;

  typedef logic [COLOR_W-1:0] grey_lut_t [PALETTE_N];

  // weight one cube digit, truncating toward zero (weights in thousandths)
  function automatic int weigh_digit(int d, int w);
    int m;
    int q;
    m = (d < 0) ? -d : d;
    q = (m * w) / 1000;
    return (d < 0) ? -q : q;
  endfunction

  // palette index -> greyscale-weighted index, built at elaboration
  function automatic grey_lut_t build_grey_lut();
    grey_lut_t lut;
    int d;
    int r;
    int g;
    int b;
    int v;
    for (int i = 0; i < PALETTE_N; i++) begin
      d = i - 16;
      r = d / 36;
      g = (d / 6) % 6;
      b = d % 6;
      v = 16 + 36 * weigh_digit(r, 299) + 6 * weigh_digit(g, 587) + weigh_digit(b, 114);
      lut[i] = COLOR_W'(v);
    end
    return lut;
  endfunction

  localparam grey_lut_t GREY_LUT = build_grey_lut();

endpackage

// ===== hw/rtl/cpsa_if.sv =====
// Valid/ready channel interfaces for the request and result words.
interface cpsa_in_if import cpsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic               greyscale;

  modport source (output valid, fg, bg, greyscale, input ready);
  modport sink   (input valid, fg, bg, greyscale, output ready);
endinterface

interface cpsa_out_if import cpsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot_index;
  logic               allocated;
  logic [COLOR_W-1:0] pair_fg;
  logic [COLOR_W-1:0] pair_bg;

  modport source (output valid, slot_index, allocated, pair_fg, pair_bg, input ready);
  modport sink   (input valid, slot_index, allocated, pair_fg, pair_bg, output ready);
endinterface

// ===== hw/rtl/color_pair_slot_allocator.sv =====
// Top level of the color pair slot allocator: key store, linear search and slot allocation.
//
// Each request word (fg, bg, greyscale) yields one result word. After reset the key store
// is cleared by a pass over every slot during which no request is taken. A request
// whose key fg*256+bg is at or above pair_limit, or that finds the next-free pointer at
// slot 0, goes straight from acceptance to the done state, from which its result word is
// loaded into the result register (slot 0 for a rejected key). An accepted key is otherwise
// compared against the stored keys of slots 0 .. next_slot-1, one key per cycle through the
// single read port of the key memory; the search ends at the first hit, or as a miss after
// slot next_slot-1. The next request is taken only once the result is loaded, later while
// the result register still holds an unaccepted word. A miss writes the key at the next-free
// slot, which advances and wraps back to reserved_base after the last slot. Results sit in
// an output register, so a new request is taken while the previous result still waits. Write
// configuration only while idle.
module color_pair_slot_allocator import cpsa_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cpsa_in_if.sink               in_if,
  cpsa_out_if.source            out_if
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] SLOT_RST  = (RST_BASE < TABLE_DEPTH) ? AW'(RST_BASE) : '0;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } cpsa_state_e;

  cpsa_state_e state_q, state_d;

  logic [LIMIT_W-1:0] pair_limit_q;
  logic [BASE_W-1:0]  reserved_base_q;

  logic [AW-1:0]      next_slot_q, next_slot_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]      scan_q, scan_d;
  logic [AW-1:0]      res_slot_q, res_slot_d;
  logic               res_alloc_q, res_alloc_d;
  logic [COLOR_W-1:0] fg_q, fg_d, bg_q, bg_d;
  logic [KEY_W-1:0]   key;

  logic [COLOR_W-1:0] grey_fg, grey_bg;
  logic [KEY_W-1:0]   key_in;
  logic               in_acc;

  // key memory and its read pipeline
  logic [KEY_W-1:0]   mem_q [TABLE_DEPTH];
  logic [KEY_W-1:0]   mem_rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic               cmp_vld_q;
  logic [AW-1:0]      cmp_idx_q;

  logic [AW-1:0]      wrap_slot;
  logic               out_load;
  logic               out_vld_q, out_vld_d;
  logic [SLOT_W-1:0]  out_slot_q;
  logic               out_alloc_q;
  logic [COLOR_W-1:0] out_fg_q, out_bg_q;

  // color conversion ahead of the key register
  cpsa_grey u_grey (
    .fg_i        (in_if.fg),
    .bg_i        (in_if.bg),
    .greyscale_i (in_if.greyscale),
    .fg_o        (grey_fg),
    .bg_o        (grey_bg)
  );

  assign key_in      = {grey_fg, grey_bg};
  assign key         = {fg_q, bg_q};
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign wrap_slot   = (32'(reserved_base_q) < TABLE_DEPTH) ? AW'(reserved_base_q) : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_limit_q    <= RST_LIMIT;
      reserved_base_q <= BASE_W'(RST_BASE);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAIR_LIMIT:    pair_limit_q    <= LIMIT_W'(cfg_data_i);
        CFG_RESERVED_BASE: reserved_base_q <= cfg_data_i[BASE_W-1:0];
      endcase
    end
  end

  // sequencer: clear pass, search, write-back of a new pair
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    scan_d      = scan_q;
    res_slot_d  = res_slot_q;
    res_alloc_d = res_alloc_q;
    fg_d        = fg_q;
    bg_d        = bg_q;
    next_slot_d = next_slot_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          fg_d        = grey_fg;
          bg_d        = grey_bg;
          scan_d      = '0;
          res_slot_d  = '0;
          res_alloc_d = 1'b0;
          if ({1'b0, key_in} >= pair_limit_q) begin
            state_d = ST_DONE;
          end else if (next_slot_q == '0) begin
            // nothing below the pointer: straight allocation
            res_slot_d  = next_slot_q;
            res_alloc_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < next_slot_q) begin
          mem_re = 1'b1;
          scan_d = scan_q + 1'b1;
        end
        if (cmp_vld_q && (mem_rdata_q == key)) begin
          res_slot_d = cmp_idx_q;
          state_d    = ST_DONE;
        end else if (cmp_vld_q && (cmp_idx_q == next_slot_q - 1'b1)) begin
          res_slot_d  = next_slot_q;
          res_alloc_d = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (res_alloc_q) begin
            mem_we      = 1'b1;
            mem_waddr   = next_slot_q;
            mem_wdata   = key;
            next_slot_d = (next_slot_q == LAST_SLOT) ? wrap_slot : next_slot_q + 1'b1;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      next_slot_q <= SLOT_RST;
      cmp_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      next_slot_q <= next_slot_d;
      cmp_vld_q   <= mem_re;
      out_vld_q   <= out_vld_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    res_slot_q  <= res_slot_d;
    res_alloc_q <= res_alloc_d;
    fg_q        <= fg_d;
    bg_q        <= bg_d;
    cmp_idx_q   <= scan_q;
  end

  // key memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[scan_q];
    end
  end

  // result register
  assign out_vld_d = out_load || (out_vld_q && !out_if.ready);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q  <= SLOT_W'({{SLOT_W{1'b0}}, res_slot_q});
      out_alloc_q <= res_alloc_q;
      out_fg_q    <= fg_q;
      out_bg_q    <= bg_q;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.slot_index = out_slot_q;
  assign out_if.allocated  = out_alloc_q;
  assign out_if.pair_fg    = out_fg_q;
  assign out_if.pair_bg    = out_bg_q;

`ifndef ASSERT_OFF
  a_ptr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(next_slot_q) < TABLE_DEPTH)
    else $error("next-free pointer outside the table");

  a_cmp_below_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (cmp_idx_q < next_slot_q))
    else $error("search read beyond the next-free pointer");

  a_alloc_at_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && res_alloc_q |-> (res_slot_q == next_slot_q))
    else $error("new pair not placed at the next-free slot");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !out_vld_q || $past(out_vld_q))
    else $error("result produced during the clear pass");
`endif

endmodule

// ===== hw/rtl/cpsa_grey.sv =====
// Optional greyscale conversion of the foreground and background colors.
module cpsa_grey import cpsa_pkg::*; (
  input  logic [COLOR_W-1:0] fg_i,
  input  logic [COLOR_W-1:0] bg_i,
  input  logic               greyscale_i,
  output logic [COLOR_W-1:0] fg_o,
  output logic [COLOR_W-1:0] bg_o
);

  // table lookup per color, bypassed when greyscale is off
  assign fg_o = greyscale_i ? GREY_LUT[fg_i] : fg_i;
  assign bg_o = greyscale_i ? GREY_LUT[bg_i] : bg_i;

endmodule
